// ----- rtl/itra_pkg.sv -----
// shared types, constants and digit encoding for the integer to radix ascii block
package itra_pkg;

	// width of the converted integer and derived sizes
	localparam int WORD_BITS = 32;
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int ADDR_W = $clog2(WORD_BITS);
	localparam int BASE_W = 6;
	localparam int CHAR_W = 8;

	// radix limits and special radix
	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;

	// ascii codes
	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] DEC_DIGITS = 8'd10;

	// input word
	typedef struct packed {
		logic signed [WORD_BITS-1:0] value;
		logic [BASE_W-1:0] base;
	} item_t;

	// output word
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic last;
	} text_t;

	// digit value to its ascii character, lower-case letters above nine
	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {{(CHAR_W - BASE_W){1'b0}}, d};
		if (dw < DEC_DIGITS) begin
			return CHAR_ZERO + dw;
		end else begin
			return CHAR_LOWER_A + dw - DEC_DIGITS;
		end
	endfunction

endpackage

// ----- rtl/integer_to_radix_ascii.sv -----
// top level: signed integer to ascii text in radix 2 to 36
// One word in, a run of characters out: an optional minus sign (negative
// values in radix 10 only), the digits most significant first in 0-9a-z, and
// a NUL word with last set. Other radixes of a negative value give the digits
// of the magnitude. A radix outside 2..36 gives only the NUL. Items are
// handled one at a time: item_stall stays high from acceptance until the NUL
// has been loaded into the output register. Each digit comes from a
// bit-serial divider (ST_DIV_START, then ST_DIV_WAIT) and is pushed into
// the digit store; the digits are then read back from the store, most
// significant first, through ST_READ and ST_EMIT. Output stalls hold the
// sequencer in ST_SIGN, ST_EMIT or ST_TERM until the output register is
// free.
module integer_to_radix_ascii (
	input  logic clk,
	input  logic arst_n,
	input  itra_pkg::item_t item,
	input  logic item_valid,
	output logic item_stall,
	output itra_pkg::text_t text,
	output logic text_valid,
	input  logic text_stall
);
	import itra_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIGN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_READ,
		ST_EMIT,
		ST_TERM
	} state_t;

	state_t state_q;
	logic [WORD_BITS-1:0] mag_q;
	logic [BASE_W-1:0] base_q;
	logic [CNT_W-1:0] ndig_q;
	text_t text_q;
	logic text_valid_q;

	logic item_take;
	logic out_free;
	logic text_load;
	logic base_ok;
	logic neg;
	logic [WORD_BITS-1:0] mag_in;
	logic div_done;
	logic [WORD_BITS-1:0] div_quo;
	logic [BASE_W-1:0] div_rem;
	logic push;
	logic pop;
	logic [CNT_W-1:0] ndig_dec;
	logic [BASE_W-1:0] rd_digit;

	// input side and magnitude of the value
	always_comb begin
		item_take = item_valid && (state_q == ST_IDLE);
		base_ok = (item.base >= BASE_MIN) && (item.base <= BASE_MAX);
		neg = item.value[WORD_BITS-1];
		mag_in = neg ? (~item.value + WORD_BITS'(1)) : item.value;
		out_free = !text_valid_q || !text_stall;
		// output word loaded this cycle
		text_load = out_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT)
			|| (state_q == ST_TERM));
		push = (state_q == ST_DIV_WAIT) && div_done;
		pop = (state_q == ST_READ);
		ndig_dec = ndig_q - CNT_W'(1);
	end

	itra_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_DIV_START),
		.dividend(mag_q),
		.divisor(base_q),
		.done(div_done),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	itra_stack u_stack (
		.clk(clk),
		.wr_en(push),
		.wr_addr(ndig_q[ADDR_W-1:0]),
		.wr_data(div_rem),
		.rd_en(pop),
		.rd_addr(ndig_dec[ADDR_W-1:0]),
		.rd_data(rd_digit)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mag_q <= '0;
			base_q <= '0;
			ndig_q <= '0;
			text_q <= '0;
			text_valid_q <= 1'b0;
		end else begin
			if (text_load) begin
				text_valid_q <= 1'b1;
			end else if (text_valid_q && !text_stall) begin
				text_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						mag_q <= mag_in;
						base_q <= item.base;
						ndig_q <= '0;
						if (!base_ok) begin
							state_q <= ST_TERM;
						end else if (neg && (item.base == BASE_DEC)) begin
							state_q <= ST_SIGN;
						end else begin
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						text_q <= '{character: CHAR_MINUS, last: 1'b0};
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						ndig_q <= ndig_q + CNT_W'(1);
						mag_q <= div_quo;
						if (div_quo == '0) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_READ: begin
					ndig_q <= ndig_dec;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						text_q <= '{character: digit_char(rd_digit), last: 1'b0};
						if (ndig_q == '0) begin
							state_q <= ST_TERM;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_TERM: begin
					if (out_free) begin
						text_q <= '{character: CHAR_NUL, last: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign text = text_q;
	assign text_valid = text_valid_q;

endmodule

// ----- rtl/itra_div.sv -----
// bit-serial restoring divider by a small radix, one quotient bit per cycle
module itra_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [itra_pkg::WORD_BITS-1:0] dividend,
	input  logic [itra_pkg::BASE_W-1:0] divisor,
	output logic done,
	output logic [itra_pkg::WORD_BITS-1:0] quotient,
	output logic [itra_pkg::BASE_W-1:0] remainder
);
	import itra_pkg::*;

	logic [WORD_BITS-1:0] quo_q;
	logic [BASE_W-1:0] rem_q;
	logic [BASE_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [BASE_W:0] trial;
	logic ge;
	logic [BASE_W:0] diff;

	// trial subtraction with the next dividend bit shifted in
	always_comb begin
		trial = {rem_q, quo_q[WORD_BITS-1]};
		ge = trial >= {1'b0, div_q};
		diff = trial - {1'b0, div_q};
	end

	// shift dividend out msb first, quotient bits in at the lsb
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			div_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(WORD_BITS);
				quo_q <= dividend;
				rem_q <= '0;
				div_q <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[WORD_BITS-2:0], ge};
				rem_q <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/itra_stack.sv -----
// digit store, one write and one registered read per cycle
module itra_stack (
	input  logic clk,
	input  logic wr_en,
	input  logic [itra_pkg::ADDR_W-1:0] wr_addr,
	input  logic [itra_pkg::BASE_W-1:0] wr_data,
	input  logic rd_en,
	input  logic [itra_pkg::ADDR_W-1:0] rd_addr,
	output logic [itra_pkg::BASE_W-1:0] rd_data
);
	import itra_pkg::*;

	logic [BASE_W-1:0] mem [WORD_BITS];
	logic [BASE_W-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
